// ----- rtl/etrle_pkg.sv -----
// Package for the escape-then-run-length encoder core.
// Beat payload types, the internal symbol-op type and shared constants.
// No dependencies.
`default_nettype none
package etrle_pkg;

	localparam int SYM_W       = 7;
	localparam int LEN_W       = 12;
	localparam int CHAR_W      = 8;
	localparam int MAX_RUN_DEF = 4095;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CHAR_W-1:0] CHAR_A    = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_Z    = 8'h5A;
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;

	typedef struct packed {
		logic [CHAR_W-1:0] text_char;
		logic              is_last;
	} in_t;

	typedef struct packed {
		logic [SYM_W-1:0] run_symbol;
		logic [LEN_W-1:0] run_length;
		logic             final_run;
	} out_t;

	typedef enum logic {
		OP_SYM   = 1'b0,
		OP_FLUSH = 1'b1
	} op_kind_t;

	typedef struct packed {
		op_kind_t         kind;
		logic [SYM_W-1:0] sym;
	} op_t;

endpackage
`default_nettype wire

// ----- rtl/etrle_fifo.sv -----
// Small register queue with push/full and pop/empty sides.
// Generic width and depth; no package dependency.
`default_nettype none
module etrle_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/etrle_front.sv -----
// Front end: accepts character beats and splits them into symbol and flush ops.
// Depends on etrle_pkg.
`default_nettype none
module etrle_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire etrle_pkg::in_t item,
	output logic               op_push,
	output etrle_pkg::op_t     op_data,
	input  wire logic          op_full
);
	import etrle_pkg::*;

	logic             pend_sym_v_q;
	logic [SYM_W-1:0] pend_sym_q;
	logic             pend_fl_q;
	logic             accept;
	logic             is_upper;
	logic             is_digit;
	logic             first_v;
	op_t              first_op;
	logic             rest_sym_v;
	logic [SYM_W-1:0] rest_sym;
	logic [CHAR_W-1:0] digit_sym;

	assign full     = pend_sym_v_q | pend_fl_q | op_full;
	assign accept   = push & ~full;
	assign is_upper = (item.text_char >= CHAR_A) && (item.text_char <= CHAR_Z);
	assign is_digit = (item.text_char >= CHAR_ZERO) && (item.text_char <= CHAR_NINE);
	assign digit_sym = item.text_char - CHAR_ZERO + CHAR_A;

	always_comb begin
		first_v       = 1'b0;
		first_op.kind = OP_SYM;
		first_op.sym  = item.text_char[SYM_W-1:0];
		rest_sym_v    = 1'b0;
		rest_sym      = CHAR_Z[SYM_W-1:0];
		priority if (item.text_char == CHAR_Z) begin
			first_v    = 1'b1;
			rest_sym_v = 1'b1;
		end else if (is_upper) begin
			first_v = 1'b1;
		end else if (is_digit) begin
			first_v      = 1'b1;
			first_op.sym = CHAR_Z[SYM_W-1:0];
			rest_sym_v   = 1'b1;
			rest_sym     = digit_sym[SYM_W-1:0];
		end else begin
			first_v       = item.is_last;
			first_op.kind = OP_FLUSH;
		end
	end

	always_comb begin
		op_push = 1'b0;
		op_data = first_op;
		priority if (pend_sym_v_q) begin
			op_push      = 1'b1;
			op_data.kind = OP_SYM;
			op_data.sym  = pend_sym_q;
		end else if (pend_fl_q) begin
			op_push      = 1'b1;
			op_data.kind = OP_FLUSH;
			op_data.sym  = '0;
		end else begin
			op_push = accept & first_v;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pend_sym_q <= rest_sym;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_sym_v_q <= 1'b0;
			pend_fl_q    <= 1'b0;
		end else if (accept) begin
			pend_sym_v_q <= rest_sym_v;
			pend_fl_q    <= item.is_last & (is_upper | is_digit);
		end else if (!op_full) begin
			if (pend_sym_v_q) begin
				pend_sym_v_q <= 1'b0;
			end else begin
				pend_fl_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/etrle_back.sv -----
// Back end: run-length state; turns symbol and flush ops into run records.
// Depends on etrle_pkg.
`default_nettype none
module etrle_back #(
	parameter int MAX_RUN = etrle_pkg::MAX_RUN_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          op_empty,
	input  wire etrle_pkg::op_t op_data,
	output logic               op_pop,
	output logic               rec_push,
	output etrle_pkg::out_t    rec_data,
	input  wire logic          rec_full
);
	import etrle_pkg::*;

	localparam int CNT_W = $clog2(MAX_RUN + 1);

	logic [SYM_W-1:0] pend_sym_q;
	logic [CNT_W-1:0] cnt_q;
	logic             open_q;
	logic             extend;

	assign op_pop = ~op_empty & ~rec_full;
	assign extend = open_q && (op_data.sym == pend_sym_q) && (cnt_q < CNT_W'(MAX_RUN));

	always_comb begin
		rec_data.run_symbol = pend_sym_q;
		rec_data.run_length = LEN_W'(cnt_q);
		rec_data.final_run  = 1'b0;
		rec_push            = 1'b0;
		unique case (op_data.kind)
			OP_SYM: begin
				rec_push = op_pop & open_q & ~extend;
			end
			OP_FLUSH: begin
				rec_push           = op_pop & open_q;
				rec_data.final_run = 1'b1;
			end
			default: begin
				rec_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_sym_q <= '0;
			cnt_q      <= '0;
			open_q     <= 1'b0;
		end else if (op_pop) begin
			unique case (op_data.kind)
				OP_SYM: begin
					if (extend) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						pend_sym_q <= op_data.sym;
						cnt_q      <= CNT_W'(1);
						open_q     <= 1'b1;
					end
				end
				OP_FLUSH: begin
					pend_sym_q <= '0;
					cnt_q      <= '0;
					open_q     <= 1'b0;
				end
				default: begin
					open_q <= open_q;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/escape_then_run_length_encoder_core.sv -----
// Top level of the escape-then-run-length encoder core.
// Depends on etrle_pkg, etrle_fifo, etrle_front and etrle_back.
//
// Usage:
// Input side is a queue write port: an item beat (text_char, is_last) is
// taken at a clock edge with push high and full low. Output side is a queue
// read port: the oldest run record sits on result while empty is low and is
// taken at an edge with pop high and empty low.
// The front splits each character into ops: a letter A to Y gives one symbol
// op, Z or a digit two, and is_last one more for the flush op; other
// characters make no op unless marked last. The front issues one op per cycle
// while the op queue is not full and takes no new item until it has issued
// every op of the last one. The back consumes one op per cycle while the
// output queue is not full and writes at most one record per op into it.
// Two-entry queues sit between front and back and before the output, so a
// stalled receiver first fills the output queue, then the op queue, and then
// full rises; nothing is lost.
// Reset clears all queues and the open run; the core is ready right after.
`default_nettype none
module escape_then_run_length_encoder_core #(
	parameter int MAX_RUN = etrle_pkg::MAX_RUN_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire etrle_pkg::in_t item,
	output logic                empty,
	input  wire logic           pop,
	output etrle_pkg::out_t     result
);
	import etrle_pkg::*;

	logic op_push;
	op_t  op_wdata;
	logic op_full;
	logic op_pop;
	op_t  op_rdata;
	logic op_empty;
	logic rec_push;
	out_t rec_wdata;
	logic rec_full;

	etrle_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.item    (item),
		.op_push (op_push),
		.op_data (op_wdata),
		.op_full (op_full)
	);

	etrle_fifo #(
		.WIDTH ($bits(op_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_op_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (op_push),
		.wdata  (op_wdata),
		.full   (op_full),
		.pop    (op_pop),
		.rdata  (op_rdata),
		.empty  (op_empty)
	);

	etrle_back #(
		.MAX_RUN (MAX_RUN)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_empty (op_empty),
		.op_data  (op_rdata),
		.op_pop   (op_pop),
		.rec_push (rec_push),
		.rec_data (rec_wdata),
		.rec_full (rec_full)
	);

	etrle_fifo #(
		.WIDTH ($bits(out_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rec_push),
		.wdata  (rec_wdata),
		.full   (rec_full),
		.pop    (pop),
		.rdata  (result),
		.empty  (empty)
	);

endmodule
`default_nettype wire

// ----- bench/etrle_run_checker.sv -----
`timescale 1ns / 100ps
// Run-record checker for the escape-then-run-length encoder core.
// Watches the item and record queues, predicts each record and compares it.
// Depends on etrle_pkg.
module etrle_run_checker #(
	parameter int MAX_RUN = etrle_pkg::MAX_RUN_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire logic            full,
	input  wire etrle_pkg::in_t  item,
	input  wire logic            empty,
	input  wire logic            pop,
	input  wire etrle_pkg::out_t result,
	output int unsigned          errors,
	output int unsigned          outstanding
);
	import etrle_pkg::*;

	out_t             records_due[$];
	out_t             want;
	logic [SYM_W-1:0] run_sym;
	int unsigned      run_len;
	logic             run_live;

	function automatic void close_run(input logic fin);
		out_t rec;
		rec.run_symbol = run_sym;
		rec.run_length = run_len[LEN_W-1:0];
		rec.final_run  = fin;
		records_due.push_back(rec);
	endfunction

	function automatic void add_symbol(input logic [SYM_W-1:0] sym);
		if (run_live && sym == run_sym && run_len < MAX_RUN) begin
			run_len++;
		end else begin
			if (run_live)
				close_run(1'b0);
			run_sym  = sym;
			run_len  = 1;
			run_live = 1'b1;
		end
	endfunction

	function automatic void encode_char(input in_t beat);
		logic [CHAR_W-1:0] mapped;
		if (beat.text_char == CHAR_Z) begin
			add_symbol(CHAR_Z[SYM_W-1:0]);
			add_symbol(CHAR_Z[SYM_W-1:0]);
		end else if (beat.text_char >= CHAR_A && beat.text_char < CHAR_Z) begin
			add_symbol(beat.text_char[SYM_W-1:0]);
		end else if (beat.text_char >= CHAR_ZERO && beat.text_char <= CHAR_NINE) begin
			// digit: escape Z, then the letter at the same offset from A
			mapped = CHAR_A + (beat.text_char - CHAR_ZERO);
			add_symbol(CHAR_Z[SYM_W-1:0]);
			add_symbol(mapped[SYM_W-1:0]);
		end
		if (beat.is_last) begin
			if (run_live)
				close_run(1'b1);
			run_sym  = '0;
			run_len  = 0;
			run_live = 1'b0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			records_due.delete();
			run_sym     = '0;
			run_len     = 0;
			run_live    = 1'b0;
			errors      = 0;
			outstanding = 0;
		end else begin
			if (pop && !empty) begin
				if (records_due.size() == 0) begin
					$error("unexpected record: run_symbol %0h run_length %0d final_run %0b",
						result.run_symbol, result.run_length, result.final_run);
					errors++;
				end else begin
					want = records_due.pop_front();
					if (result.run_symbol !== want.run_symbol) begin
						$error("run_symbol: expected %0h, actual %0h",
							want.run_symbol, result.run_symbol);
						errors++;
					end
					if (result.run_length !== want.run_length) begin
						$error("run_length: expected %0d, actual %0d",
							want.run_length, result.run_length);
						errors++;
					end
					if (result.final_run !== want.final_run) begin
						$error("final_run: expected %0b, actual %0b",
							want.final_run, result.final_run);
						errors++;
					end
				end
			end
			if (push && !full)
				encode_char(item);
			outstanding = records_due.size();
		end
	end

endmodule

// ----- bench/escape_then_run_length_encoder_core_test.sv -----
`timescale 1ns / 100ps
// Testbench top for the escape-then-run-length encoder core.
// Drives character beats and record pops with random idling and gives the verdict;
// depends on etrle_pkg, the core and etrle_run_checker.
module escape_then_run_length_encoder_core_test;
	import etrle_pkg::*;

	localparam int CYCLE_LIMIT = 900000;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic        empty;
	logic        pop;
	in_t         item;
	out_t        result;
	int unsigned errors;
	int unsigned outstanding;
	int unsigned cycles = 0;
	int unsigned rx_hold = 0;
	logic        calm = 1'b0;

	escape_then_run_length_encoder_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	etrle_run_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.item        (item),
		.empty       (empty),
		.pop         (pop),
		.result      (result),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic put_char(input logic [CHAR_W-1:0] ch, input logic lst);
		int unsigned gap;
		item <= '{text_char: ch, is_last: lst};
		push <= 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 11);
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic wait_drained();
		push <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		@(negedge clk);
	endtask

	function automatic logic [CHAR_W-1:0] random_char(input logic [CHAR_W-1:0] prev);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return prev;
		if (r < 70)
			return CHAR_W'(CHAR_A + $urandom_range(0, 4));
		if (r < 78)
			return CHAR_Z;
		if (r < 88)
			return CHAR_W'(CHAR_ZERO + $urandom_range(0, 9));
		if (r < 94)
			return CHAR_W'(CHAR_A + $urandom_range(0, 25));
		return CHAR_W'($urandom_range(0, 255));
	endfunction

	// record side
	initial begin
		int unsigned gap;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (rx_hold != 0) begin
				pop <= 1'b0;
				gap = rx_hold;
				rx_hold = 0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				pop <= 1'b0;
				gap = $urandom_range(1, 11);
			end else begin
				pop <= 1'b1;
				gap = $urandom_range(1, 6);
			end
			repeat (gap) @(negedge clk);
		end
	end

	// character side
	initial begin
		int unsigned       n;
		logic [CHAR_W-1:0] ch;
		arst_n = 1'b0;
		push   = 1'b0;
		item   = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		put_char("A", 1'b1);
		put_char("Y", 1'b0);
		put_char("Y", 1'b0);
		put_char(CHAR_Z, 1'b0);
		put_char(CHAR_ZERO, 1'b0);
		put_char(CHAR_NINE, 1'b0);
		// characters outside both ranges, at their edges and top bit
		put_char(8'h40, 1'b0);
		put_char(8'h5B, 1'b0);
		put_char(8'h2F, 1'b0);
		put_char(8'h3A, 1'b0);
		put_char(8'h00, 1'b0);
		put_char(8'hFF, 1'b0);
		put_char(8'h61, 1'b0);
		put_char(8'h7A, 1'b1);
		// last with nothing open
		put_char(8'h23, 1'b1);
		// three records from one beat
		put_char("B", 1'b0);
		put_char("5", 1'b1);
		put_char(CHAR_Z, 1'b1);
		put_char(8'h80, 1'b0);
		put_char(CHAR_Z, 1'b0);
		put_char("A", 1'b1);

		// long receiver stall so the core backs up
		rx_hold = 80;
		for (n = 0; n < 24; n++)
			put_char(CHAR_W'(CHAR_A + n), n == 23);
		wait_drained();

		ch = CHAR_A;
		for (n = 0; n < 305; n++) begin
			if (n == 255)
				calm = 1'b1;
			ch = random_char(ch);
			put_char(ch, n == 304 || $urandom_range(0, 11) == 0);
		end
		push <= 1'b0;

		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
